// ----- rtl/prescaled_interval_timer_assert.svh -----
// Assertion macros for the interval timer top level.
`ifndef PRESCALED_INTERVAL_TIMER_ASSERT_SVH
`define PRESCALED_INTERVAL_TIMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pit: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pit: next-cycle check failed");

`endif

// ----- rtl/pit_pkg.sv -----
// Types, codes and helpers for the prescaled interval timer.
`default_nettype none

package pit_pkg;

    localparam int REMAIN_W = 19;
    localparam int BYTE_W   = 8;
    localparam int SEL_W    = 2;
    localparam int SHIFT_W  = 4;

    // Request kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Prescale select codes
    localparam logic [SEL_W-1:0] SEL_1    = 2'd0;
    localparam logic [SEL_W-1:0] SEL_8    = 2'd1;
    localparam logic [SEL_W-1:0] SEL_64   = 2'd2;
    localparam logic [SEL_W-1:0] SEL_1024 = 2'd3;

    localparam logic [SEL_W-1:0] RESET_SEL = SEL_64;

    // Lowest remaining time still shown after expiry
    localparam logic signed [REMAIN_W-1:0] STOP_LIMIT = -19'sd255;

    typedef struct packed {
        logic              op;
        logic [SEL_W-1:0]  prescale_select;
        logic [BYTE_W-1:0] interval_count;
        logic [BYTE_W-1:0] cycle_count;
    } req_t;

    typedef struct packed {
        logic              running;
        logic              interrupt_flag;
        logic [BYTE_W-1:0] timer_value;
    } rsp_t;

    typedef struct packed {
        logic running;
        logic expired;
        logic flag;
    } status_t;

    function automatic logic [SHIFT_W-1:0] shift_of(input logic [SEL_W-1:0] sel);
        logic [SHIFT_W-1:0] sh;
        unique case (sel)
            SEL_1:    sh = 4'd0;
            SEL_8:    sh = 4'd3;
            SEL_64:   sh = 4'd6;
            SEL_1024: sh = 4'd10;
            default:  sh = 4'd0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pit_core.sv -----
// Timer state and next-state logic: one request applied per step.
`default_nettype none

module pit_core
    import pit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire req_t req,
    output rsp_t      rsp,
    output status_t   status
);

    logic signed [REMAIN_W-1:0] remain_reg, remain_next;
    logic [SEL_W-1:0]           sel_reg, sel_next;
    logic                       expired_reg, expired_next;
    logic                       running_reg, running_next;
    logic [BYTE_W-1:0]          byte_reg, byte_next;
    logic                       flag_reg, flag_next;

    logic signed [REMAIN_W-1:0] diff;
    logic [REMAIN_W-1:0]        load_time;
    logic [REMAIN_W-1:0]        reload_time;
    logic [REMAIN_W-1:0]        scaled;
    logic                       diff_pos;

    assign diff        = remain_reg - signed'({{(REMAIN_W-BYTE_W){1'b0}}, req.cycle_count});
    assign load_time   = {{(REMAIN_W-BYTE_W){1'b0}}, req.interval_count}
                         << shift_of(req.prescale_select);
    assign reload_time = {{(REMAIN_W-1){1'b0}}, 1'b1} << shift_of(sel_reg);
    assign scaled      = REMAIN_W'(diff) >> shift_of(sel_reg);
    assign diff_pos    = !diff[REMAIN_W-1] && (diff != '0);

    always_comb
    begin
        remain_next  = remain_reg;
        sel_next     = sel_reg;
        expired_next = expired_reg;
        running_next = running_reg;
        byte_next    = byte_reg;
        flag_next    = flag_reg;
        if (req.op == OP_START)
        begin
            sel_next     = req.prescale_select;
            remain_next  = signed'(load_time);
            running_next = 1'b1;
            expired_next = 1'b0;
        end
        else if (running_reg)
        begin
            remain_next = diff;
            if (!expired_reg && diff_pos)
            begin
                byte_next = scaled[BYTE_W-1:0];
            end
            else if (expired_reg)
            begin
                if (diff >= STOP_LIMIT)
                begin
                    byte_next = diff[BYTE_W-1:0];
                end
                else
                begin
                    byte_next    = '0;
                    running_next = 1'b0;
                end
            end
            else
            begin
                // Expire: reload one prescale period and raise the flag
                remain_next  = signed'(reload_time);
                byte_next    = '0;
                flag_next    = 1'b1;
                expired_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg  <= '0;
            sel_reg     <= RESET_SEL;
            expired_reg <= 1'b0;
            running_reg <= 1'b0;
            byte_reg    <= '0;
            flag_reg    <= 1'b0;
        end
        else if (step)
        begin
            remain_reg  <= remain_next;
            sel_reg     <= sel_next;
            expired_reg <= expired_next;
            running_reg <= running_next;
            byte_reg    <= byte_next;
            flag_reg    <= flag_next;
        end
    end

    assign rsp.timer_value    = byte_next;
    assign rsp.interrupt_flag = flag_next;
    assign rsp.running        = running_next;

    assign status.running = running_reg;
    assign status.expired = expired_reg;
    assign status.flag    = flag_reg;

endmodule

`default_nettype wire

// ----- rtl/prescaled_interval_timer.sv -----
// Interval timer with a 1/8/64/1024 prescaler: a start request loads
// prescale * interval, tick requests subtract elapsed clock counts, and each
// request yields one result with the readable timer byte, the sticky interrupt
// flag and the running bit. A request is taken every clock cycle unless the
// master side stalls; its result passes the input register, then the result
// register, before the master side can take it. The single update of the
// timer state between those registers sets the one-request-per-cycle rate.
// The output register lets one new request be taken while a finished result
// still waits on the master side.
`default_nettype none

module prescaled_interval_timer
    import pit_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [1:0] prescale_select, [9:2] interval_count,
                                            // [17:10] cycle_count, [23:18] zero
    input  wire logic        s_axis_tuser,  // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [7:0] timer_value, [8] interrupt_flag,
                                            // [9] running, [15:10] zero
);

`include "prescaled_interval_timer_assert.svh"

    logic    in_valid_reg;
    req_t    req_reg;
    logic    out_valid_reg;
    rsp_t    out_reg;
    logic    advance;
    rsp_t    rsp;
    status_t status;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg.op              <= s_axis_tuser;
            req_reg.prescale_select <= s_axis_tdata[1:0];
            req_reg.interval_count  <= s_axis_tdata[9:2];
            req_reg.cycle_count     <= s_axis_tdata[17:10];
        end
    end

    pit_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .req    (req_reg),
        .rsp    (rsp),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= rsp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.running, out_reg.interrupt_flag, out_reg.timer_value};

    `PIT_ASSERT_NEXT(a_flag_sticky, clk, rst_n, status.flag, status.flag)
    `PIT_ASSERT_NOW(a_expired_has_flag, clk, rst_n, status.expired, status.flag)
    `PIT_ASSERT_NEXT(a_start_runs, clk, rst_n, advance && (req_reg.op == OP_START),
                     out_reg.running && status.running && !status.expired)

endmodule

`default_nettype wire

// ----- bench/prescaled_interval_timer_tb.sv -----
// Self-checking testbench for the prescaled interval timer, with a scoreboard class.
`default_nettype none

module prescaled_interval_timer_tb
    import pit_pkg::*;
();

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 10;

    class timer_checker;
        logic signed [REMAIN_W-1:0] remaining;
        logic [10:0]                prescale;
        logic [SHIFT_W-1:0]         shift;
        logic                       expired;
        logic                       running;
        logic [BYTE_W-1:0]          timer_byte;
        logic                       flag;
        rsp_t                       expected_readings[$];
        int                         errors;

        function new();
            remaining  = '0;
            shift      = 4'd6;
            prescale   = 11'd64;
            expired    = 1'b0;
            running    = 1'b0;
            timer_byte = '0;
            flag       = 1'b0;
            errors     = 0;
        endfunction

        function bit is_running();
            return running;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Advance the timer by one accepted request and queue the reading it yields.
        function void note_request(input req_t r);
            rsp_t reading;
            if (r.op == OP_START)
            begin
                case (r.prescale_select)
                    SEL_1:   shift = 4'd0;
                    SEL_8:   shift = 4'd3;
                    SEL_64:  shift = 4'd6;
                    default: shift = 4'd10;
                endcase
                prescale  = 11'd1 << shift;
                remaining = REMAIN_W'(r.interval_count) << shift;
                running   = 1'b1;
                expired   = 1'b0;
            end
            else if (running)
            begin
                remaining = remaining - REMAIN_W'(r.cycle_count);
                if (!expired && remaining > 0)
                begin
                    timer_byte = BYTE_W'(remaining >> shift);
                end
                else if (expired)
                begin
                    if (remaining >= STOP_LIMIT)
                    begin
                        timer_byte = remaining[BYTE_W-1:0];
                    end
                    else
                    begin
                        timer_byte = '0;
                        running    = 1'b0;
                    end
                end
                else
                begin
                    // expiry: reload one prescale period and latch the flag
                    remaining  = REMAIN_W'(prescale);
                    timer_byte = '0;
                    flag       = 1'b1;
                    expired    = 1'b1;
                end
            end
            reading.timer_value    = timer_byte;
            reading.interrupt_flag = flag;
            reading.running        = running;
            expected_readings.push_back(reading);
        endfunction

        function void check_result(input logic [15:0] data);
            rsp_t got;
            rsp_t want;
            got = rsp_t'(data[9:0]);
            if (expected_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: value %0d flag %0b running %0b",
                             got.timer_value, got.interrupt_flag, got.running);
                return;
            end
            want = expected_readings.pop_front();
            if (got.timer_value != want.timer_value
                || got.interrupt_flag != want.interrupt_flag
                || got.running != want.running)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected %0d flag %0b run %0b, got %0d flag %0b run %0b",
                             want.timer_value, want.interrupt_flag, want.running,
                             got.timer_value, got.interrupt_flag, got.running);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [1:0] prescale_select, [9:2] interval_count,
                                 // [17:10] cycle_count, [23:18] zero
    logic        s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] timer_value, [8] interrupt_flag,
                                 // [9] running, [15:10] zero

    timer_checker board;
    int           src_idle_pct;
    int           dst_idle_pct;
    int           stall_cycles;

    prescaled_interval_timer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after the handshake.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {6'd0, r.cycle_count, r.interval_count, r.prescale_select};
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(r);
        @(negedge clk);
    endtask

    // Hold the request side until every queued reading has come back.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int count);
        req_t r;
        bit   restart;
        repeat (count)
        begin
            restart = board.is_running() ? ($urandom_range(99) < 4)
                                         : ($urandom_range(99) < 75);
            r.prescale_select = SEL_W'($urandom_range(3));
            r.cycle_count     = BYTE_W'($urandom_range(255));
            if (restart)
            begin
                r.op = OP_START;
                if (r.prescale_select == SEL_1024)
                    r.interval_count = ($urandom_range(99) < 85) ? BYTE_W'($urandom_range(3))
                                                                 : BYTE_W'($urandom_range(255));
                else
                    r.interval_count = ($urandom_range(99) < 50) ? BYTE_W'($urandom_range(15))
                                                                 : BYTE_W'($urandom_range(255));
            end
            else
            begin
                r.op             = OP_TICK;
                r.interval_count = BYTE_W'($urandom_range(255));
                if ($urandom_range(99) < 30)
                    r.cycle_count = BYTE_W'($urandom_range(7));
            end
            send_request(r);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        m_axis_tready = 1'b0;
        src_idle_pct  = 15;
        dst_idle_pct  = 60;
        stall_cycles  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ticks before any start leave the reset state alone
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd0});
        send_request('{OP_TICK,  SEL_1024, 8'd255, 8'd255});
        // zero interval expires on the first tick, even a zero-cycle one
        send_request('{OP_START, SEL_1,    8'd0,   8'd77});
        send_request('{OP_TICK,  SEL_8,    8'd19,  8'd0});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd0});
        send_request('{OP_TICK,  SEL_64,   8'd200, 8'd255});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd2});
        // stopped: tick changes nothing
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd5});
        send_request('{OP_START, SEL_1024, 8'd255, 8'd0});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd255});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd0});
        // divide-by-64 run through expiry down to the stop limit
        send_request('{OP_START, SEL_64,   8'd1,   8'd255});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd63});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd1});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd0});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd255});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd64});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd1});
        send_request('{OP_START, SEL_8,    8'd170, 8'd85});
        send_request('{OP_TICK,  SEL_1024, 8'd85,  8'd85});
        send_request('{OP_START, SEL_1,    8'd85,  8'd170});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd170});
        // reload of 1024 shows its low byte wrapped
        send_request('{OP_START, SEL_1024, 8'd0,   8'd0});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd0});
        send_request('{OP_TICK,  SEL_1,    8'd0,   8'd1});
        wait_drain();

        run_random(370);
        wait_drain();
        src_idle_pct = 60;
        dst_idle_pct = 15;
        run_random(370);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random(370);
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/pit_pkg.sv
rtl/pit_core.sv
rtl/prescaled_interval_timer.sv
bench/prescaled_interval_timer_tb.sv
